/* sv/vcrc_pkg.sv */
// ----------------------------------------------------------------------------
// vcrc_pkg: shared types and constants for the VPD climate relay controller
// Holds the payload structs, register indexes, the datapath command set and
// the fixed-point constants of the Tetens vapor pressure calculation.
// ----------------------------------------------------------------------------
package vcrc_pkg;

  // Field widths.
  localparam int TEMP_W    = 11;
  localparam int HUM_W     = 10;
  localparam int VPD_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Default for the fraction bits kept of the exponent remainder.
  localparam int EXP_TABLE_BITS_DEF = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VPD_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VPD_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 3'd3;

  // Arithmetic widths.
  localparam int NUM_W  = 42;   // divider dividend
  localparam int DEN_W  = 22;   // divider divisor
  localparam int QUO_W  = 24;   // divider quotient bits
  localparam int TERM_W = 25;   // Taylor term, Q24 with room for 1.0
  localparam int V_W    = 34;   // running value of e^x in Q24
  localparam int ACC_W  = 47;   // low partial product
  localparam int HALF_W = 17;   // half of the value split for products
  localparam int N_W    = 6;    // integer part of the exponent

  // Fixed-point constants.
  localparam logic [29:0] E_Q28      = 30'd729683222;
  localparam logic [29:0] INV_E_Q28  = 30'd98751886;
  localparam logic [14:0] TETENS_B   = 15'd17269;
  localparam int          TETENS_C   = 2383;
  localparam logic [25:0] SVP_BASE   = 26'd61078;
  localparam logic [9:0]  HUM_FULL   = 10'd1000;
  localparam logic [63:0] SCALE_RND  = 64'd838860800000;
  localparam int          TAY_TERMS  = 12;
  localparam int          HEAT_MARGIN = 150;

  // Final scaling divides by 100000 as a shift by five and a divide by 3125,
  // the latter by multiplying with floor(2^43 / 3125).
  localparam logic [11:0] QDIV_C     = 12'd3125;
  localparam logic [31:0] QDIV_RECIP = 32'd2814749767;

  // Payload types.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic                     reading_valid;
  } in_item_t;

  typedef struct packed {
    logic [VPD_W-1:0] vpd_value;
    logic             fan_on;
    logic             heater_on;
  } out_item_t;

  // Datapath command set.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_NUM,
    OP_DIV,
    OP_PREP,
    OP_TMUL,
    OP_TEST,
    OP_TCORR,
    OP_PLO,
    OP_PHI,
    OP_SLO,
    OP_SHI,
    OP_QEST,
    OP_QCORR,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_valid;
    logic div_done;
    logic k_last;
    logic n_zero;
    logic out_free;
  } dp_stat_t;

  // floor(2^28 / k) for the Taylor term divisors.
  function automatic logic [28:0] tay_recip(input logic [3:0] k);
    logic [28:0] r;
    case (k)
      4'd1:    r = 29'd268435456;
      4'd2:    r = 29'd134217728;
      4'd3:    r = 29'd89478485;
      4'd4:    r = 29'd67108864;
      4'd5:    r = 29'd53687091;
      4'd6:    r = 29'd44739242;
      4'd7:    r = 29'd38347922;
      4'd8:    r = 29'd33554432;
      4'd9:    r = 29'd29826161;
      4'd10:   r = 29'd26843545;
      4'd11:   r = 29'd24403223;
      4'd12:   r = 29'd22369621;
      default: r = 29'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/vcrc_div.sv */
// ----------------------------------------------------------------------------
// vcrc_div: restoring divider
// Produces one quotient bit per cycle, most significant first. The dividend
// must be below the divisor shifted up by the quotient width.
// ----------------------------------------------------------------------------
module vcrc_div
  import vcrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  logic [SH_W-1:0]  rem;
  logic [SH_W-1:0]  den_sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [SH_W:0]    trial;

  // Trial subtraction of the shifted divisor.
  assign trial = {1'b0, rem} - {1'b0, den_sh};

  // Iteration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Remainder, divisor and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= SH_W'(num);
      den_sh <= SH_W'(den) << (QUO_W - 1);
      cnt    <= CNT_W'(QUO_W - 1);
      quot   <= '0;
    end else if (busy) begin
      if (!trial[SH_W]) begin
        rem <= trial[SH_W-1:0];
      end
      quot      <= {quot[QUO_W-2:0], ~trial[SH_W]};
      den_sh    <= den_sh >> 1;
      cnt       <= cnt - 1'b1;
    end
  end

endmodule

/* sv/vcrc_dp.sv */
// ----------------------------------------------------------------------------
// vcrc_dp: VPD datapath
// Holds the reading, the arithmetic registers, the configuration registers,
// the two relays and the result register, and executes one command a cycle.
// ----------------------------------------------------------------------------
module vcrc_dp
  import vcrc_pkg::*;
#(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int RQ_W = EXP_TABLE_BITS + 1;
  localparam logic [16:0] RND_HALF = 17'(1) << (15 - EXP_TABLE_BITS);

  // Configuration registers.
  logic [VPD_W-1:0]         vpd_low_limit;
  logic [VPD_W-1:0]         vpd_high_limit;
  logic signed [TEMP_W-1:0] temp_low_limit;
  logic signed [TEMP_W-1:0] temp_high_limit;

  // Reading and arithmetic registers.
  logic signed [TEMP_W-1:0] t_reg;
  logic [HUM_W-1:0]         h_reg;
  logic                     rv_reg;
  logic [NUM_W-1:0]         num_reg;
  logic [DEN_W-1:0]         den_reg;
  logic signed [N_W-1:0]    n_reg;
  logic [23:0]              r24_reg;
  logic [TERM_W-1:0]        term_reg;
  logic [TERM_W-1:0]        p_reg;
  logic [TERM_W-1:0]        est_reg;
  logic [V_W-1:0]           v_reg;
  logic [3:0]               k_reg;
  logic [ACC_W-1:0]         acc_reg;
  logic [19:0]              qest_reg;
  logic [19:0]              quo_reg;
  logic [VPD_W-1:0]         vpd_out;
  logic                     fan_state;
  logic                     heater_state;

  // Divider connection.
  logic             div_done;
  logic [QUO_W-1:0] div_quot;

  // Combinational terms.
  logic [TEMP_W-1:0]        t_mag;
  logic signed [12:0]       t_sum;
  logic [11:0]              t_pos;
  logic [25:0]              mag_prod;
  logic [20:0]              half_den;
  logic [21:0]              den_v;
  logic signed [21:0]       x_v;
  logic [16:0]              r_sum;
  logic [RQ_W-1:0]          rq;
  logic                     rq_carry;
  logic [48:0]              tmul_prod;
  logic [53:0]              test_prod;
  logic [28:0]              est_k;
  logic [28:0]              corr_rem;
  logic [TERM_W-1:0]        term_new;
  logic [29:0]              pw_const;
  logic [9:0]               hum_rest;
  logic [25:0]              scl_fac;
  logic [29:0]              mul_b;
  logic [ACC_W-1:0]         lo_prod;
  logic [ACC_W-1:0]         hi_prod;
  logic [63:0]              hi_sum;
  logic [30:0]              q_num;
  logic [62:0]              qest_prod;
  logic [30:0]              qest_mul;
  logic [30:0]              qrem;
  logic [VPD_W-1:0]         vpd_sat;
  logic [VPD_W-1:0]         vpd_res;
  logic                     out_free;
  logic                     heat_on_cond;
  logic signed [17:0]       heat_margin;

  vcrc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV),
    .num   (num_reg),
    .den   (den_reg),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Exponent numerator and denominator from the temperature.
  assign t_mag    = t_reg[TEMP_W-1] ? TEMP_W'(-t_reg) : TEMP_W'(t_reg);
  assign t_sum    = 13'(t_reg) + 13'(TETENS_C);
  assign t_pos    = t_sum[11:0];
  assign mag_prod = 26'(t_mag) * 26'(TETENS_B);
  assign half_den = 21'(t_pos) * 21'(500);
  assign den_v    = 22'(t_pos) * 22'(1000);

  // Signed exponent split into integer part and rounded fraction.
  assign x_v      = t_reg[TEMP_W-1] ? -$signed({1'b0, div_quot[20:0]})
                                    : $signed({1'b0, div_quot[20:0]});
  assign r_sum    = {1'b0, x_v[15:0]} + RND_HALF;
  assign rq       = RQ_W'(r_sum >> (16 - EXP_TABLE_BITS));
  assign rq_carry = rq[EXP_TABLE_BITS];

  // Taylor series step: multiply, reciprocal estimate, correction.
  assign tmul_prod = 49'(term_reg) * 49'(r24_reg);
  assign test_prod = 54'(p_reg) * 54'(tay_recip(k_reg));
  assign est_k     = 29'(est_reg) * 29'(k_reg);
  assign corr_rem  = 29'(p_reg) - est_k;
  assign term_new  = est_reg + TERM_W'(corr_rem >= 29'(k_reg));

  // Split products for the power step and the final scaling.
  assign pw_const = n_reg[N_W-1] ? INV_E_Q28 : E_Q28;
  assign hum_rest = HUM_FULL - h_reg;
  assign scl_fac  = SVP_BASE * 26'(hum_rest);
  assign mul_b    = (cmd.op == OP_PLO || cmd.op == OP_PHI) ? pw_const : 30'(scl_fac);
  assign lo_prod  = ACC_W'(v_reg[HALF_W-1:0]) * ACC_W'(mul_b);
  assign hi_prod  = ACC_W'(v_reg[V_W-1:HALF_W]) * ACC_W'(mul_b);
  assign hi_sum   = {hi_prod, {HALF_W{1'b0}}} + 64'(acc_reg);

  // Division of the scaled value by 100000: the low five bits are dropped,
  // then a reciprocal estimate by 3125 is corrected by at most one.
  assign q_num     = num_reg[35:5];
  assign qest_prod = 63'(q_num) * 63'(QDIV_RECIP);
  assign qest_mul  = 31'(qest_reg) * 31'(QDIV_C);
  assign qrem      = q_num - qest_mul;

  // Final value with saturation and the special cases.
  assign vpd_sat = (quo_reg[19:VPD_W] != '0) ? '1 : quo_reg[VPD_W-1:0];
  assign vpd_res = (!rv_reg || h_reg > HUM_FULL) ? '0 : vpd_sat;
  assign heat_margin  = $signed({2'b00, vpd_high_limit}) - $signed(18'(HEAT_MARGIN));
  assign heat_on_cond = (t_reg <= temp_low_limit) &&
                        ($signed({2'b00, vpd_res}) < heat_margin);
  assign out_free = !out_valid || !out_stall;

  // Status toward the controller.
  assign stat.rd_valid = rv_reg;
  assign stat.div_done = div_done;
  assign stat.k_last   = (k_reg == 4'(TAY_TERMS));
  assign stat.n_zero   = (n_reg == '0);
  assign stat.out_free = out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpd_low_limit   <= '0;
      vpd_high_limit  <= '0;
      temp_low_limit  <= '0;
      temp_high_limit <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VPD_LOW:   vpd_low_limit   <= cfg_data;
        CFG_VPD_HIGH:  vpd_high_limit  <= cfg_data;
        CFG_TEMP_LOW:  temp_low_limit  <= cfg_data[TEMP_W-1:0];
        CFG_TEMP_HIGH: temp_high_limit <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Arithmetic registers, one command per cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        t_reg  <= in_data.temperature;
        h_reg  <= in_data.humidity;
        rv_reg <= in_data.reading_valid;
      end
      OP_NUM: begin
        num_reg <= {mag_prod, 16'h0000} + NUM_W'(half_den);
        den_reg <= den_v;
      end
      OP_PREP: begin
        n_reg    <= x_v[21:16] + N_W'(rq_carry);
        r24_reg  <= rq_carry ? 24'h0 : 24'(rq[EXP_TABLE_BITS-1:0]) << (24 - EXP_TABLE_BITS);
        term_reg <= TERM_W'(1) << 24;
        v_reg    <= V_W'(1) << 24;
        k_reg    <= 4'd1;
      end
      OP_TMUL: p_reg <= tmul_prod[48:24];
      OP_TEST: est_reg <= test_prod[52:28];
      OP_TCORR: begin
        term_reg <= term_new;
        v_reg    <= v_reg + V_W'(term_new);
        k_reg    <= k_reg + 4'd1;
      end
      OP_PLO: acc_reg <= lo_prod;
      OP_PHI: begin
        v_reg <= V_W'(hi_sum >> 28);
        n_reg <= n_reg[N_W-1] ? n_reg + 1'b1 : n_reg - 1'b1;
      end
      OP_SLO: acc_reg <= lo_prod;
      OP_SHI: num_reg <= NUM_W'((hi_sum + SCALE_RND) >> 24);
      OP_QEST: qest_reg <= qest_prod[62:43];
      OP_QCORR: quo_reg <= qest_reg + 20'(qrem >= 31'(QDIV_C));
      default: ;
    endcase
  end

  // Relays and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_state    <= 1'b0;
      heater_state <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.op == OP_FIN && out_free) begin
        out_valid <= 1'b1;
        if (rv_reg) begin
          if (vpd_res <= vpd_low_limit) begin
            fan_state <= 1'b1;
          end else if (vpd_res >= vpd_high_limit) begin
            fan_state <= 1'b0;
          end
          if (heat_on_cond) begin
            heater_state <= 1'b1;
          end else if (t_reg >= temp_high_limit || vpd_res >= vpd_high_limit) begin
            heater_state <= 1'b0;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result value, captured together with the relay update.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN && out_free) begin
      vpd_out <= vpd_res;
    end
  end

  assign out_data.vpd_value = vpd_out;
  assign out_data.fan_on    = fan_state;
  assign out_data.heater_on = heater_state;

endmodule

/* sv/vcrc_ctrl.sv */
// ----------------------------------------------------------------------------
// vcrc_ctrl: VPD sequencer
// Steps the datapath through division, Taylor series, power loop, scaling
// and the relay update for one reading at a time.
// ----------------------------------------------------------------------------
module vcrc_ctrl
  import vcrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NUM,
    S_DIV1,
    S_WAIT1,
    S_PREP,
    S_TMUL,
    S_TEST,
    S_TCORR,
    S_PCHK,
    S_PLO,
    S_PHI,
    S_SLO,
    S_SHI,
    S_QEST,
    S_QCORR,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // Command decode and next state.
  always_comb begin
    cmd.op     = OP_NOP;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_NUM;
        end
      end
      S_NUM: begin
        cmd.op     = OP_NUM;
        state_next = stat.rd_valid ? S_DIV1 : S_FIN;
      end
      S_DIV1: begin
        cmd.op     = OP_DIV;
        state_next = S_WAIT1;
      end
      S_WAIT1: if (stat.div_done) state_next = S_PREP;
      S_PREP: begin
        cmd.op     = OP_PREP;
        state_next = S_TMUL;
      end
      S_TMUL: begin
        cmd.op     = OP_TMUL;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.op     = OP_TEST;
        state_next = S_TCORR;
      end
      S_TCORR: begin
        cmd.op     = OP_TCORR;
        state_next = stat.k_last ? S_PCHK : S_TMUL;
      end
      S_PCHK: state_next = stat.n_zero ? S_SLO : S_PLO;
      S_PLO: begin
        cmd.op     = OP_PLO;
        state_next = S_PHI;
      end
      S_PHI: begin
        cmd.op     = OP_PHI;
        state_next = S_PCHK;
      end
      S_SLO: begin
        cmd.op     = OP_SLO;
        state_next = S_SHI;
      end
      S_SHI: begin
        cmd.op     = OP_SHI;
        state_next = S_QEST;
      end
      S_QEST: begin
        cmd.op     = OP_QEST;
        state_next = S_QCORR;
      end
      S_QCORR: begin
        cmd.op     = OP_QCORR;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/vpd_climate_relay_controller_core.sv */
// ----------------------------------------------------------------------------
// vpd_climate_relay_controller_core: VPD climate relay controller
// Computes vapor pressure deficit from a temperature and humidity reading
// and drives fan and heater hysteresis relays.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_stall   in_item_t (temperature, humidity,
//                                           reading_valid)
//  out      output     out_valid/out_stall out_item_t (vpd_value, fan_on,
//                                           heater_on)
//  cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A valid reading's time from accept to accept grows with |n|, where n is
// the exponent's integer part: it takes a divider pass, the Taylor series,
// one power step per unit of n, and the load, setup, scaling and relay update.
// An invalid reading skips the division, series, power loop and scaling.
// Reset is synchronous and clears the sequencer, relays and configuration.
// The next reading is taken while a finished result waits in the output
// register; a stalled output holds the sequencer only at its last step.
// ----------------------------------------------------------------------------
module vpd_climate_relay_controller_core
  import vcrc_pkg::*;
#(
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  vcrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  vcrc_dp #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_vpd_climate_relay_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_vpd_climate_relay_controller_core: self-checking bench for the VPD core
// Drives temperature/humidity requests with random gaps, stalls the result
// side at random, and checks every result against a fixed-point predictor
// of the Tetens VPD calculation and the two hysteresis relays. Register
// settings change between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_vpd_climate_relay_controller_core;
  import vcrc_pkg::*;

  localparam int FRAC_BITS = EXP_TABLE_BITS_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_PHASES = 9;
  localparam int RAND_PER_PHASE = 185;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  vpd_climate_relay_controller_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and relays.
  logic [15:0]        fan_low_vpd, shutoff_vpd;
  logic signed [10:0] heat_low_temp, heat_high_temp;
  logic               fan_relay, heater_relay;

  in_item_t  reading_queue[$];
  out_item_t expected_results[$];
  int        mismatch_count;
  int        quiet_cycles;
  int        in_gap, out_gap;
  logic      in_took;
  logic      idle_enable;

  // Clock.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (!idle_enable || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Tetens VPD in Pa, fixed point throughout.
  function automatic logic [15:0] tetens_vpd(input int t, input int h);
    longint unsigned den, mag, q, xo, r16, rq, r24, term, ex, p, res, scale;
    longint          x;
    int              n;
    if (h > 1000) return 16'd0;
    den = longint'(t + 2383) * 64'd1000;
    mag = longint'(t < 0 ? -t : t) * 64'd17269 * 64'd65536;
    q = (mag + den / 2) / den;
    x = (t < 0) ? -longint'(q) : longint'(q);
    xo = x + (longint'(16) << 16);
    n = int'(xo >> 16) - 16;
    r16 = xo & 64'hFFFF;
    rq = (r16 + (64'd1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
    if (rq == (64'd1 << FRAC_BITS)) begin
      n++;
      rq = 0;
    end
    r24 = rq << (24 - FRAC_BITS);
    term = 64'd1 << 24;
    ex = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * r24) >> 24) / k;
      ex += term;
    end
    while (n > 0) begin
      ex = (ex * 64'd729683222) >> 28;
      n--;
    end
    while (n < 0) begin
      ex = (ex * 64'd98751886) >> 28;
      n++;
    end
    scale = 64'd100000 << 24;
    p = 64'd61078 * ex * longint'(1000 - h);
    res = (p + (scale >> 1)) / scale;
    return (res > 65535) ? 16'hFFFF : res[15:0];
  endfunction

  // Relay update for one accepted reading; returns the expected result.
  function automatic out_item_t predict_relays(input in_item_t rd);
    out_item_t o;
    int        t, vpd;
    o = '0;
    if (rd.reading_valid) begin
      t = rd.temperature;
      vpd = tetens_vpd(t, rd.humidity);
      o.vpd_value = vpd[15:0];
      if (vpd <= fan_low_vpd) fan_relay = 1'b1;
      else if (vpd >= shutoff_vpd) fan_relay = 1'b0;
      if (t <= heat_low_temp && vpd < int'(shutoff_vpd) - 150) heater_relay = 1'b1;
      else if (t >= heat_high_temp || vpd >= shutoff_vpd) heater_relay = 1'b0;
    end
    o.fan_on = fan_relay;
    o.heater_on = heater_relay;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Request driver: changes inputs on the falling edge.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (reading_queue.size() > 0) begin
        in_data <= reading_queue.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_gap <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: samples on the rising edge, predicts and checks.
  always @(posedge clk) begin
    out_item_t want;
    logic      any_hs;
    any_hs = (in_valid && !in_stall) || (cfg_valid && cfg_ready) ||
             (out_valid && !out_stall);
    in_took <= !rst && in_valid && !in_stall;
    if (!rst) begin
      quiet_cycles <= any_hs ? 0 : quiet_cycles + 1;
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_relays(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.vpd_value, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_data.vpd_value !== want.vpd_value)
            report_mismatch("vpd_value", out_data.vpd_value, want.vpd_value);
          if (out_data.fan_on !== want.fan_on)
            report_mismatch("fan_on", out_data.fan_on, want.fan_on);
          if (out_data.heater_on !== want.heater_on)
            report_mismatch("heater_on", out_data.heater_on, want.heater_on);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One register write; the predictor copy follows at the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_VPD_LOW:   fan_low_vpd = value;
      CFG_VPD_HIGH:  shutoff_vpd = value;
      CFG_TEMP_LOW:  heat_low_temp = value[10:0];
      CFG_TEMP_HIGH: heat_high_temp = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_reading(input int t, input int h, input bit ok);
    in_item_t rd;
    rd.temperature = t[10:0];
    rd.humidity = h[9:0];
    rd.reading_valid = ok;
    reading_queue.push_back(rd);
  endtask

  // Wait until every request has gone through and the core is quiet.
  task automatic drain();
    while (reading_queue.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  // Random reading: mostly in-range and valid, some full-width noise.
  task automatic add_random_reading();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      add_reading($urandom, $urandom, $urandom_range(0, 1));
    else if (r == 1)
      add_reading($urandom_range(0, 1200) - 400, $urandom_range(0, 1000), 1'b0);
    else
      add_reading($urandom_range(0, 1200) - 400, $urandom_range(0, 1000), 1'b1);
  endtask

  initial begin
    int lo;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_took = 1'b0;
    in_gap = 0;
    out_gap = 0;
    idle_enable = 1'b1;
    mismatch_count = 0;
    quiet_cycles = 0;
    fan_low_vpd = '0;
    shutoff_vpd = '0;
    heat_low_temp = '0;
    heat_high_temp = '0;
    fan_relay = 1'b0;
    heater_relay = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed readings under reset limits.
    add_reading(-400, 0, 1'b1);
    add_reading(800, 0, 1'b1);
    add_reading(800, 1000, 1'b1);
    add_reading(-1024, 512, 1'b1);
    add_reading(1023, 0, 1'b1);
    add_reading(0, 1001, 1'b1);
    add_reading(250, 1023, 1'b1);
    add_reading(250, 500, 1'b0);
    drain();

    // Fan and heater hysteresis, the heater margin and an ignored index.
    write_reg(CFG_VPD_LOW, 16'd500);
    write_reg(CFG_VPD_HIGH, 16'd1500);
    write_reg(CFG_TEMP_LOW, 16'd180);
    write_reg(CFG_TEMP_HIGH, 16'd260);
    write_reg(3'd5, 16'hFFFF);
    add_reading(150, 900, 1'b1);   // low VPD, cold: both on
    add_reading(220, 700, 1'b1);   // between limits: both hold
    add_reading(270, 600, 1'b1);   // warm: heater off
    add_reading(300, 100, 1'b1);   // high VPD: fan off
    add_reading(150, 900, 1'b0);   // invalid: hold
    add_reading(100, 400, 1'b1);   // cold and VPD below margin: heater on
    add_reading(150, 950, 1'b1);
    drain();

    // Heater margin below zero and the register extremes.
    write_reg(CFG_VPD_HIGH, 16'd100);
    write_reg(CFG_VPD_LOW, 16'hFFFF);
    write_reg(CFG_TEMP_LOW, 16'h03FF);
    write_reg(CFG_TEMP_HIGH, 16'h0400);
    add_reading(-400, 1000, 1'b1);
    add_reading(0, 990, 1'b1);
    add_reading(800, 0, 1'b1);
    drain();

    // Random phases over a range of settings.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      case (ph)
        0: begin
          write_reg(CFG_VPD_LOW, 16'd0);
          write_reg(CFG_VPD_HIGH, 16'hFFFF);
          write_reg(CFG_TEMP_LOW, -16'sd400);
          write_reg(CFG_TEMP_HIGH, 16'd800);
        end
        1: begin
          write_reg(CFG_VPD_LOW, 16'hFFFF);
          write_reg(CFG_VPD_HIGH, 16'd0);
          write_reg(CFG_TEMP_LOW, 16'd800);
          write_reg(CFG_TEMP_HIGH, -16'sd400);
        end
        default: begin
          lo = $urandom_range(0, 4000);
          write_reg(CFG_VPD_LOW, 16'(lo));
          write_reg(CFG_VPD_HIGH, 16'(lo + $urandom_range(0, 5000)));
          lo = $urandom_range(0, 600) - 200;
          write_reg(CFG_TEMP_LOW, 16'(lo));
          write_reg(CFG_TEMP_HIGH, 16'(lo + $urandom_range(0, 300)));
          write_reg(CFG_IDX_W'($urandom_range(4, 7)), 16'($urandom));
        end
      endcase
      repeat (RAND_PER_PHASE) add_random_reading();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
